>>> design/fpfa_pkg.sv
// Fixed partition fit allocator: shared types, sizes and policy codes.
// Used by fpfa_cell and fixed_partition_fit_allocator_unit; depends on nothing.
`default_nettype none

package fpfa_pkg;

   // Sizing of the partition store and the size field
   localparam int PARTITION_COUNT = 8;
   localparam int SIZE_WIDTH      = 16;
   localparam int IDX_WIDTH       = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;

   // Fixed field widths of the transactions
   localparam int SLOT_WIDTH      = 3;
   localparam int POLICY_WIDTH    = 2;
   localparam int REQ_DATA_WIDTH  = ((SLOT_WIDTH + SIZE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH  = ((SLOT_WIDTH + SIZE_WIDTH + 7) / 8) * 8;

   // Fit policy codes; the unused code behaves as first fit
   localparam logic [POLICY_WIDTH-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_WIDTH-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_WIDTH-1:0] POLICY_WORST = 2'd2;

   // Transaction kinds on req_tuser
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   // Search packet handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [SIZE_WIDTH-1:0] size;
      logic                  found;
      logic [SIZE_WIDTH-1:0] best_cap;
      logic [IDX_WIDTH-1:0]  best_idx;
   } scan_type;

   // Capacity write broadcast to all cells
   typedef struct packed {
      logic                  en;
      logic [IDX_WIDTH-1:0]  idx;
      logic [SIZE_WIDTH-1:0] value;
   } wr_type;

endpackage

`default_nettype wire

>>> design/fixed_partition_fit_allocator_unit.sv
// Fixed partition fit allocator: a chain of partition cells searched by a travelling packet.
// Depends on fpfa_pkg and fpfa_cell.
//
// Usage:
//   req channel: tuser is the kind (0 load a partition capacity, 1 allocation request);
//   tdata carries the partition slot and the size. A load writes one capacity in the
//   cycle it is taken and gives no response; a load to a slot beyond the store is ignored.
//   A request sends a search packet down the row of PARTITION_COUNT cells, one cell per
//   cycle while the chain is not stalled, passing through each cell's packet register to
//   the end of the chain; the chosen partition is then debited and the response
//   registered. req_tready is low while a search is in flight.
//   rsp channel: tuser is the grant flag; tdata carries the partition index and the
//   capacity left (both zero when refused). The response register holds while the
//   receiver stalls, and a finished search waits at the end of the chain until the
//   register is free; loads and new requests are taken while a response waits.
//   csr channel: writes the fit policy (0 first, 1 best, 2 worst, 3 as first); always ready.
//   Reset clears every capacity to zero, the policy to first fit and all valid flags.
`default_nettype none

module fixed_partition_fit_allocator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata: partition_slot [2:0], size_value [SIZE_WIDTH+2:3], zero padding above
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [fpfa_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  wire logic                                 req_tuser,   // func
   // rsp_tdata: chosen_partition [2:0], capacity_left [SIZE_WIDTH+2:3], zero padding above
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [fpfa_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   output logic                                      rsp_tuser,   // granted
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [fpfa_pkg::POLICY_WIDTH-1:0]    csr_data
);

   localparam int N  = fpfa_pkg::PARTITION_COUNT;
   localparam int SW = fpfa_pkg::SIZE_WIDTH;
   localparam int LW = fpfa_pkg::SLOT_WIDTH;

   logic [fpfa_pkg::POLICY_WIDTH-1:0] policy_ff;
   logic                              busy_ff;
   logic                              busy_in;
   logic                              rsp_valid_ff;
   logic                              rsp_granted_ff;
   logic [LW-1:0]                     rsp_slot_ff;
   logic [SW-1:0]                     rsp_cap_ff;

   fpfa_pkg::scan_type                scan_chain [N+1];
   fpfa_pkg::scan_type                last_scan;
   fpfa_pkg::wr_type                  wr;
   logic [N-1:0]                      stage_valid;
   logic                              req_accept;
   logic                              load_accept;
   logic                              slot_ok;
   logic                              advance;
   logic                              complete;
   logic [LW-1:0]                     req_slot;
   logic [SW-1:0]                     req_size;
   logic [SW-1:0]                     left;

   // Field unpacking and handshake decode
   assign req_slot    = req_tdata[LW-1:0];
   assign req_size    = req_tdata[LW+SW-1:LW];
   assign req_tready  = !busy_ff;
   assign req_accept  = req_tvalid && req_tready && (req_tuser == fpfa_pkg::FUNC_REQUEST);
   assign load_accept = req_tvalid && req_tready && (req_tuser == fpfa_pkg::FUNC_LOAD);
   assign slot_ok     = (32'(req_slot) < N);
   assign csr_ready   = 1'b1;

   // Chain stalls only when a finished search meets a full, stalled response register
   assign last_scan = scan_chain[N];
   assign advance   = !(last_scan.valid && rsp_valid_ff && !rsp_tready);
   assign complete  = last_scan.valid && advance;
   assign left      = last_scan.best_cap - last_scan.size;

   // Packet entering the first cell
   always_comb begin
      scan_chain[0]          = '0;
      scan_chain[0].valid    = req_accept;
      scan_chain[0].size     = req_size;
   end

   // Row of partition cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      fpfa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (fpfa_pkg::IDX_WIDTH'(i)),
         .advance    (advance),
         .policy     (policy_ff),
         .scan_in    (scan_chain[i]),
         .scan_out   (scan_chain[i+1]),
         .wr         (wr)
      );
      assign stage_valid[i] = scan_chain[i+1].valid;
   end

   // Capacity write: debit on a granted search, else a load transaction
   always_comb begin
      wr = '0;
      if (complete) begin
         wr.en    = last_scan.found;
         wr.idx   = last_scan.best_idx;
         wr.value = left;
      end else if (load_accept && slot_ok) begin
         wr.en    = 1'b1;
         wr.idx   = fpfa_pkg::IDX_WIDTH'(req_slot);
         wr.value = req_size;
      end
   end

   // Search occupancy
   always_comb begin
      busy_in = busy_ff;
      if (complete) begin
         busy_in = 1'b0;
      end else if (req_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         policy_ff <= fpfa_pkg::POLICY_FIRST;
      end else begin
         busy_ff <= busy_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_data;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (complete) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (complete) begin
         rsp_granted_ff <= last_scan.found;
         rsp_slot_ff    <= last_scan.found ? LW'(last_scan.best_idx) : '0;
         rsp_cap_ff     <= last_scan.found ? left : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = fpfa_pkg::RSP_DATA_WIDTH'({rsp_cap_ff, rsp_slot_ff});

   // Checks
   a_one_packet: assert property (@(posedge clock) disable iff (reset)
      $onehot0(stage_valid))
      else $error("more than one search packet in the chain");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (stage_valid == '0))
      else $error("search packet present while idle");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("request taken without marking a search in flight");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("refused response carries non-zero data");

endmodule

`default_nettype wire

>>> design/fpfa_cell.sv
// One partition cell: holds a remaining capacity and updates the passing search packet.
// Depends on fpfa_pkg.
`default_nettype none

module fpfa_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [fpfa_pkg::IDX_WIDTH-1:0] cell_index,
   input  wire logic                          advance,
   input  wire logic [fpfa_pkg::POLICY_WIDTH-1:0] policy,
   input  wire fpfa_pkg::scan_type            scan_in,
   output fpfa_pkg::scan_type                 scan_out,
   input  wire fpfa_pkg::wr_type              wr
);

   logic [fpfa_pkg::SIZE_WIDTH-1:0] cap_ff;
   fpfa_pkg::scan_type              scan_ff;
   fpfa_pkg::scan_type              scan_in_next;
   logic                            fits;
   logic                            better;
   logic                            take;

   // Compare this partition against the packet so far; strict compares keep lowest index
   always_comb begin
      fits   = (cap_ff >= scan_in.size);
      better = ((policy == fpfa_pkg::POLICY_BEST)  && (cap_ff < scan_in.best_cap)) ||
               ((policy == fpfa_pkg::POLICY_WORST) && (cap_ff > scan_in.best_cap));
      take   = scan_in.valid && fits && (!scan_in.found || better);
      scan_in_next          = scan_in;
      scan_in_next.found    = scan_in.found || (scan_in.valid && fits);
      if (take) begin
         scan_in_next.best_cap = cap_ff;
         scan_in_next.best_idx = cell_index;
      end
   end

   // Packet stage towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (advance) begin
         scan_ff <= scan_in_next;
      end
   end

   // Capacity store for this partition
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (wr.en && (wr.idx == cell_index)) begin
         cap_ff <= wr.value;
      end
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire
